// ===== hdl/cils_pkg.sv =====
// Shared types and constants for the compacting indexed log store.
// Holds operation and status codes and the memory control struct.
// No dependencies.
`default_nettype none

package cils_pkg;

    // Widths of absolute log indexes and terms.
    localparam int IDX_W  = 31;
    localparam int TERM_W = 31;

    // Highest index that can be held; an append at this last index is refused.
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    // Operation codes carried on the opcode port.
    typedef enum logic [1:0] {
        OP_APPEND   = 2'd0,
        OP_READ     = 2'd1,
        OP_SNAPSHOT = 2'd2,
        OP_TRUNCATE = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Control strobes from the sequencer to the entry memories.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/cils_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Read data updates only on a read strobe and holds otherwise.
// No dependencies.
`default_nettype none

module cils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    // Write and registered read share the one address port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_array[addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cils_ctrl.sv =====
// Sequencer of the compacting indexed log store: ring pointers, base, tail
// tracking, memory requests and the output register.
// Depends on cils_pkg.
`default_nettype none

module cils_ctrl #(
    parameter int DEPTH         = 1024,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Request channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    opcode,
    input  wire logic [cils_pkg::IDX_W-1:0]    log_index,
    input  wire logic [cils_pkg::TERM_W-1:0]   entry_term,
    input  wire logic [PAYLOAD_WIDTH-1:0]      entry_payload,
    // Entry memory port
    output cils_pkg::mem_ctl_t                 mem_ctl,
    output logic      [$clog2(DEPTH)-1:0]      mem_addr,
    output logic      [cils_pkg::TERM_W-1:0]   mem_wr_term,
    output logic      [PAYLOAD_WIDTH-1:0]      mem_wr_payload,
    input  wire logic [cils_pkg::TERM_W-1:0]   mem_rd_term,
    input  wire logic [PAYLOAD_WIDTH-1:0]      mem_rd_payload,
    // Result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [1:0]                    status,
    output logic      [cils_pkg::TERM_W-1:0]   read_term,
    output logic      [PAYLOAD_WIDTH-1:0]      read_payload,
    output logic      [cils_pkg::IDX_W-1:0]    last_index,
    output logic      [cils_pkg::TERM_W-1:0]   last_term
);

    import cils_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W:0]    DEPTH_SLOTS = (ADDR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0]   DEPTH_CNT   = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    // Ring slot of the k-th live entry; k may not exceed DEPTH.
    function automatic logic [ADDR_W-1:0] slot_of(
        input logic [ADDR_W-1:0] head,
        input logic [ADDR_W-1:0] k
    );
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, k};
        if (sum >= DEPTH_SLOTS)
        begin
            sum = sum - DEPTH_SLOTS;
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Control state
    state_t              state_reg,      state_next;
    logic [ADDR_W-1:0]   head_reg,       head_next;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic [IDX_W-1:0]    base_idx_reg,   base_idx_next;
    logic [TERM_W-1:0]   base_term_reg,  base_term_next;
    logic [IDX_W-1:0]    last_idx_reg,   last_idx_next;
    logic [TERM_W-1:0]   last_term_reg,  last_term_next;
    status_t             status_pend_reg, status_pend_next;
    logic                hit_reg,        hit_next;
    logic                trunc_rd_reg,   trunc_rd_next;
    logic                out_valid_reg,  out_valid_next;

    // Captured request word
    op_t                      op_reg,   op_next;
    logic [IDX_W-1:0]         idx_reg,  idx_next;
    logic [TERM_W-1:0]        term_reg, term_next;
    logic [PAYLOAD_WIDTH-1:0] pay_reg,  pay_next;

    // Output word
    status_t                  status_out_reg, status_out_next;
    logic [TERM_W-1:0]        rterm_out_reg,  rterm_out_next;
    logic [PAYLOAD_WIDTH-1:0] rpay_out_reg,   rpay_out_next;
    logic [IDX_W-1:0]         lidx_out_reg,   lidx_out_next;
    logic [TERM_W-1:0]        lterm_out_reg,  lterm_out_next;

    // Index arithmetic against the base and tail.
    logic             above;
    logic             in_range;
    logic             full;
    logic [IDX_W-1:0] diff;
    logic [IDX_W-1:0] off;
    logic [IDX_W-1:0] off_prev;
    logic [TERM_W-1:0] tail_term;

    assign above    = idx_reg > base_idx_reg;
    assign in_range = above && (idx_reg <= last_idx_reg);
    assign diff     = idx_reg - base_idx_reg;
    assign off      = diff - IDX_W'(1);
    assign off_prev = diff - IDX_W'(2);
    assign full     = (count_reg == DEPTH_CNT) || (last_idx_reg == IDX_MAX);
    assign tail_term = trunc_rd_reg ? mem_rd_term : last_term_reg;

    // Sequencer: capture, execute against the memory, then form the result.
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        base_idx_next    = base_idx_reg;
        base_term_next   = base_term_reg;
        last_idx_next    = last_idx_reg;
        last_term_next   = last_term_reg;
        status_pend_next = status_pend_reg;
        hit_next         = hit_reg;
        trunc_rd_next    = trunc_rd_reg;
        out_valid_next   = out_valid_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        term_next        = term_reg;
        pay_next         = pay_reg;
        status_out_next  = status_out_reg;
        rterm_out_next   = rterm_out_reg;
        rpay_out_next    = rpay_out_reg;
        lidx_out_next    = lidx_out_reg;
        lterm_out_next   = lterm_out_reg;
        mem_ctl          = '0;
        mem_addr         = slot_of(head_reg, count_reg[ADDR_W-1:0]);

        // The result word leaves when the consumer takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op_t'(opcode);
                    idx_next   = log_index;
                    term_next  = entry_term;
                    pay_next   = entry_payload;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                status_pend_next = ST_OK;
                hit_next         = 1'b0;
                trunc_rd_next    = 1'b0;
                state_next       = S_RESP;
                unique case (op_reg)
                    OP_APPEND:
                    begin
                        if (full)
                        begin
                            status_pend_next = ST_FULL;
                        end
                        else
                        begin
                            mem_ctl.wr_en  = 1'b1;
                            count_next     = count_reg + CNT_W'(1);
                            last_idx_next  = last_idx_reg + IDX_W'(1);
                            last_term_next = term_reg;
                        end
                    end

                    OP_READ:
                    begin
                        if (in_range)
                        begin
                            mem_ctl.rd_en = 1'b1;
                            mem_addr      = slot_of(head_reg, off[ADDR_W-1:0]);
                            hit_next      = 1'b1;
                        end
                        else
                        begin
                            status_pend_next = ST_RANGE;
                        end
                    end

                    OP_SNAPSHOT:
                    begin
                        if (above)
                        begin
                            base_idx_next  = idx_reg;
                            base_term_next = term_reg;
                            if (idx_reg < last_idx_reg)
                            begin
                                // Drop the leading entries; the tail stays put.
                                head_next  = slot_of(head_reg, diff[ADDR_W-1:0]);
                                count_next = count_reg - diff[CNT_W-1:0];
                            end
                            else
                            begin
                                // The snapshot covers every live entry.
                                count_next     = '0;
                                last_idx_next  = idx_reg;
                                last_term_next = term_reg;
                            end
                        end
                    end

                    OP_TRUNCATE:
                    begin
                        if (in_range)
                        begin
                            count_next    = off[CNT_W-1:0];
                            last_idx_next = idx_reg - IDX_W'(1);
                            if (diff == IDX_W'(1))
                            begin
                                last_term_next = base_term_reg;
                            end
                            else
                            begin
                                // Fetch the term of the new tail entry.
                                mem_ctl.rd_en = 1'b1;
                                mem_addr      = slot_of(head_reg, off_prev[ADDR_W-1:0]);
                                trunc_rd_next = 1'b1;
                            end
                        end
                    end
                endcase
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    status_out_next = status_pend_reg;
                    rterm_out_next  = hit_reg ? mem_rd_term : '0;
                    rpay_out_next   = hit_reg ? mem_rd_payload : '0;
                    lidx_out_next   = last_idx_reg;
                    lterm_out_next  = tail_term;
                    last_term_next  = tail_term;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            base_idx_reg    <= '0;
            base_term_reg   <= '0;
            last_idx_reg    <= '0;
            last_term_reg   <= '0;
            status_pend_reg <= ST_OK;
            hit_reg         <= 1'b0;
            trunc_rd_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            base_idx_reg    <= base_idx_next;
            base_term_reg   <= base_term_next;
            last_idx_reg    <= last_idx_next;
            last_term_reg   <= last_term_next;
            status_pend_reg <= status_pend_next;
            hit_reg         <= hit_next;
            trunc_rd_reg    <= trunc_rd_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        term_reg       <= term_next;
        pay_reg        <= pay_next;
        status_out_reg <= status_out_next;
        rterm_out_reg  <= rterm_out_next;
        rpay_out_reg   <= rpay_out_next;
        lidx_out_reg   <= lidx_out_next;
        lterm_out_reg  <= lterm_out_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign mem_wr_term    = term_reg;
    assign mem_wr_payload = pay_reg;
    assign out_valid      = out_valid_reg;
    assign status         = status_out_reg;
    assign read_term      = rterm_out_reg;
    assign read_payload   = rpay_out_reg;
    assign last_index     = lidx_out_reg;
    assign last_term      = lterm_out_reg;

    // The ring never holds more entries than it has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
    else $error("entry count exceeds ring depth");

    // The tracked last index always equals base plus entries held.
    assert property (@(posedge clk) disable iff (!rst_n)
        last_idx_reg == base_idx_reg + IDX_W'(count_reg))
    else $error("last index out of step with base and count");

    // An empty log reports the base term as its last term.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && count_reg == '0) |-> last_term_reg == base_term_reg)
    else $error("empty log last term differs from base term");

    // A result word appears only out of the response step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
    else $error("result word raised outside response step");

    // Memory writes happen only while executing an append.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> (state_reg == S_EXEC && op_reg == OP_APPEND))
    else $error("entry memory written outside an append");

endmodule

`default_nettype wire

// ===== hdl/compacting_indexed_log_store_core.sv =====
// Compacting indexed log store: a ring of log entries above a snapshot base,
// with append, read by index, snapshot compaction and tail truncation. Each
// request word is first captured, then takes the pointer update and at most
// one access to the entry memories, and then forms the result from the
// registered memory read; a stalled result word lengthens the last step
// until the output register frees. Only one request is in flight.
// The entry memories need no clearing after reset, since only live entries are
// ever read. Depends on cils_pkg, cils_ram and cils_ctrl.
`default_nettype none

module compacting_indexed_log_store_core #(
    parameter int DEPTH         = 1024,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  opcode,
    input  wire logic [cils_pkg::IDX_W-1:0]  log_index,
    input  wire logic [cils_pkg::TERM_W-1:0] entry_term,
    input  wire logic [PAYLOAD_WIDTH-1:0]    entry_payload,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [1:0]                  status,
    output logic      [cils_pkg::TERM_W-1:0] read_term,
    output logic      [PAYLOAD_WIDTH-1:0]    read_payload,
    output logic      [cils_pkg::IDX_W-1:0]  last_index,
    output logic      [cils_pkg::TERM_W-1:0] last_term
);

    import cils_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    mem_ctl_t                 mem_ctl;
    logic [ADDR_W-1:0]        mem_addr;
    logic [TERM_W-1:0]        mem_wr_term;
    logic [PAYLOAD_WIDTH-1:0] mem_wr_payload;
    logic [TERM_W-1:0]        mem_rd_term;
    logic [PAYLOAD_WIDTH-1:0] mem_rd_payload;

    // Term memory of the entry ring.
    cils_ram #(
        .WIDTH (TERM_W),
        .DEPTH (DEPTH)
    ) u_term_ram (
        .clk     (clk),
        .wr_en   (mem_ctl.wr_en),
        .rd_en   (mem_ctl.rd_en),
        .addr    (mem_addr),
        .wr_data (mem_wr_term),
        .rd_data (mem_rd_term)
    );

    // Payload memory of the entry ring.
    cils_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (DEPTH)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (mem_ctl.wr_en),
        .rd_en   (mem_ctl.rd_en),
        .addr    (mem_addr),
        .wr_data (mem_wr_payload),
        .rd_data (mem_rd_payload)
    );

    // Sequencer, pointers and output register.
    cils_ctrl #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .log_index      (log_index),
        .entry_term     (entry_term),
        .entry_payload  (entry_payload),
        .mem_ctl        (mem_ctl),
        .mem_addr       (mem_addr),
        .mem_wr_term    (mem_wr_term),
        .mem_wr_payload (mem_wr_payload),
        .mem_rd_term    (mem_rd_term),
        .mem_rd_payload (mem_rd_payload),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_term      (read_term),
        .read_payload   (read_payload),
        .last_index     (last_index),
        .last_term      (last_term)
    );

endmodule

`default_nettype wire
